// ----- hw/rtl/sdp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_pkg: shared types and constants of the signed decimal parser
// Character codes, phase and error encodings, range kinds and the item and
// result structures passed between the parser stages.
// ----------------------------------------------------------------------------
package sdp_pkg;

  // character codes
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;

  // range limits
  localparam logic [31:0] U8_MAX      = 32'h0000_00FF;
  localparam logic [31:0] S16_POS_MAX = 32'h0000_7FFF;
  localparam logic [31:0] S16_NEG_MAX = 32'h0000_8000;

  typedef enum logic [1:0] {
    PH_SEEK   = 2'd0,
    PH_SIGN   = 2'd1,
    PH_DIGITS = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    ERR_OK        = 3'd0,
    ERR_NO_START  = 3'd1,
    ERR_NO_DIGITS = 3'd2,
    ERR_OVERFLOW  = 3'd3,
    ERR_RANGE     = 3'd4
  } err_e;

  typedef enum logic [1:0] {
    KIND_U8  = 2'd0,
    KIND_U32 = 2'd1,
    KIND_S16 = 2'd2
  } kind_e;

  localparam logic [1:0] KIND_RESET = KIND_U32;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last_char;
  } char_item_t;

  typedef struct packed {
    logic signed [32:0] value;
    logic [2:0]         error_code;
  } result_t;

endpackage

// ----- hw/rtl/sdp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_if: handshake channels of the signed decimal parser
// Character input, result output and the result_kind write channel, each
// with valid, ready and its payload.
// ----------------------------------------------------------------------------
interface sdp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

interface sdp_result_if;
  logic               valid;
  logic               ready;
  logic signed [32:0] value;
  logic [2:0]         error_code;

  modport source (output valid, output value, output error_code, input ready);
  modport sink (input valid, input value, input error_code, output ready);
endinterface

interface sdp_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/sdp_in_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_in_stage: input register
// Holds one character beat; refills in the same cycle the step logic takes it.
// ----------------------------------------------------------------------------
module sdp_in_stage
  import sdp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  char_item_t in_item_i,
  output logic       in_ready_o,
  input  logic       take_i,
  output logic       item_valid_o,
  output char_item_t item_o
);

  logic       valid_q, valid_d;
  char_item_t item_q;

  // free when empty or drained this cycle
  assign in_ready_o = !valid_q || take_i;

  always_comb begin
    valid_d = valid_q;
    if (in_ready_o) begin
      valid_d = in_valid_i;
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      item_q <= in_item_i;
    end
  end

  assign item_valid_o = valid_q;
  assign item_o       = item_q;

endmodule

// ----- hw/rtl/sdp_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_step: per-character parse step; range checks a finished number
// Holds phase, sign and accumulator; one character per cycle, while the
// result register can take a result, updates them with a multiply-by-ten add.
// ----------------------------------------------------------------------------
module sdp_step
  import sdp_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [1:0] kind_i,
  input  logic       item_valid_i,
  input  char_item_t item_i,
  input  logic       res_ready_i,
  output logic       take_o,
  output logic       res_valid_o,
  output result_t    res_o
);

  phase_e      phase_q, phase_d;
  logic        neg_q, neg_d;
  logic [31:0] acc_q, acc_d;

  logic        fire;
  logic        is_digit, is_space, is_sign;
  logic [7:0]  digit_off;
  logic [35:0] mac;
  logic        emit, fin;
  err_e        err;
  logic        range_ok;
  logic [32:0] fin_val;
  logic [32:0] out_val;

  assign fire   = item_valid_i && res_ready_i;
  assign take_o = fire;

  // character classes
  assign is_digit  = (item_i.char_code >= CHAR_ZERO) && (item_i.char_code <= CHAR_NINE);
  assign is_space  = (item_i.char_code == CHAR_SPACE) || (item_i.char_code == CHAR_TAB);
  assign is_sign   = (item_i.char_code == CHAR_MINUS) || (item_i.char_code == CHAR_PLUS);
  assign digit_off = item_i.char_code - CHAR_ZERO;

  // acc * 10 + digit, exact in 36 bits
  assign mac = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0} + {32'd0, digit_off[3:0]};

  // next state and result selection
  always_comb begin
    phase_d = phase_q;
    neg_d   = neg_q;
    acc_d   = acc_q;
    emit    = 1'b0;
    fin     = 1'b0;
    err     = ERR_OK;
    case (phase_q)
      PH_SEEK: begin
        if (is_space) begin
          emit = item_i.last_char;
          err  = ERR_NO_START;
        end else if (is_sign) begin
          neg_d   = (item_i.char_code == CHAR_MINUS);
          phase_d = PH_SIGN;
          emit    = item_i.last_char;
          err     = ERR_NO_DIGITS;
        end else if (!is_digit) begin
          emit = 1'b1;
          err  = ERR_NO_START;
        end else begin
          neg_d   = 1'b0;
          acc_d   = {28'd0, digit_off[3:0]};
          phase_d = PH_DIGITS;
          fin     = item_i.last_char;
        end
      end
      PH_SIGN: begin
        if (!is_digit) begin
          emit = 1'b1;
          err  = ERR_NO_DIGITS;
        end else begin
          acc_d   = {28'd0, digit_off[3:0]};
          phase_d = PH_DIGITS;
          fin     = item_i.last_char;
        end
      end
      default: begin
        if (!is_digit) begin
          fin = 1'b1;
        end else if (mac[35:32] != 4'd0) begin
          emit = 1'b1;
          err  = ERR_OVERFLOW;
        end else begin
          acc_d   = mac[31:0];
          phase_d = PH_DIGITS;
          fin     = item_i.last_char;
        end
      end
    endcase
  end

  // range check of a finished number
  always_comb begin
    range_ok = 1'b0;
    fin_val  = {1'b0, acc_d};
    case (kind_e'(kind_i))
      KIND_U8: begin
        range_ok = !neg_d && (acc_d <= U8_MAX);
      end
      KIND_U32: begin
        range_ok = !neg_d;
      end
      KIND_S16: begin
        if (neg_d) begin
          range_ok = (acc_d <= S16_NEG_MAX);
          fin_val  = 33'd0 - {1'b0, acc_d};
        end else begin
          range_ok = (acc_d <= S16_POS_MAX);
        end
      end
      default: begin
        range_ok = 1'b0;
      end
    endcase
  end

  // result payload
  always_comb begin
    res_o.error_code = err;
    out_val          = 33'd0;
    if (fin) begin
      res_o.error_code = range_ok ? ERR_OK : ERR_RANGE;
      out_val          = range_ok ? fin_val : 33'd0;
    end
    res_o.value = $signed(out_val);
  end

  assign res_valid_o = fire && (emit || fin);

  // number state, cleared after every result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SEEK;
      neg_q   <= 1'b0;
      acc_q   <= 32'd0;
    end else if (fire) begin
      if (emit || fin) begin
        phase_q <= PH_SEEK;
        neg_q   <= 1'b0;
        acc_q   <= 32'd0;
      end else begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
      end
    end
  end

endmodule

// ----- hw/rtl/sdp_out_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sdp_out_stage: result register
// Holds one result beat until taken; accepts a new one in the cycle it drains.
// ----------------------------------------------------------------------------
module sdp_out_stage
  import sdp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    res_ready_o,
  output logic    out_valid_o,
  output result_t out_o,
  input  logic    out_ready_i
);

  logic    valid_q, valid_d;
  result_t res_q;

  assign res_ready_o = !valid_q || out_ready_i;

  always_comb begin
    valid_d = valid_q;
    if (res_ready_o) begin
      valid_d = res_valid_i;
    end
  end

  // occupancy flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload, no reset
  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      res_q <= res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign out_o       = res_q;

endmodule

// ----- hw/rtl/signed_decimal_parser.sv -----
`timescale 1ns / 1ps
// Path: the character that ends a result passes the input register, then the
//   parse step, and the result is held in the result register.
// Throughput: one character per cycle while the result register can take a result.
// Reset: rst_ni clears phase, sign, accumulator and both stage flags;
//   result_kind returns to unsigned 32-bit.
// ----------------------------------------------------------------------------
// signed_decimal_parser: ASCII decimal integer parser
// Skips blanks, takes an optional sign and decimal digits, and returns the
// value or an error code after the range check selected by result_kind.
// ----------------------------------------------------------------------------
module signed_decimal_parser
  import sdp_pkg::*;
(
  input logic          clk_i,
  input logic          rst_ni,
  sdp_char_if.sink     char_i,
  sdp_result_if.source result_o,
  sdp_cfg_if.sink      cfg_i
);

  logic [1:0] kind_q;
  char_item_t in_item;
  char_item_t item;
  logic       item_valid;
  logic       take;
  logic       res_valid;
  logic       res_ready;
  result_t    res;
  result_t    out_res;

  // range kind register; the user must write it only when idle, the block itself does not enforce it
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= KIND_RESET;
    end else if (cfg_i.valid) begin
      kind_q <= cfg_i.data;
    end
  end

  // input register
  assign in_item.char_code = char_i.char_code;
  assign in_item.last_char = char_i.last_char;

  sdp_in_stage u_in (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (char_i.valid),
    .in_item_i    (in_item),
    .in_ready_o   (char_i.ready),
    .take_i       (take),
    .item_valid_o (item_valid),
    .item_o       (item)
  );

  // parse step
  sdp_step u_step (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .kind_i       (kind_q),
    .item_valid_i (item_valid),
    .item_i       (item),
    .res_ready_i  (res_ready),
    .take_o       (take),
    .res_valid_o  (res_valid),
    .res_o        (res)
  );

  // result register
  sdp_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res),
    .res_ready_o (res_ready),
    .out_valid_o (result_o.valid),
    .out_o       (out_res),
    .out_ready_i (result_o.ready)
  );

  assign result_o.value      = out_res.value;
  assign result_o.error_code = out_res.error_code;

  // a failed parse carries a zero value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.error_code != ERR_OK)) |-> (result_o.value == 33'sd0))
    else $error("error result with nonzero value");

  // error codes stay within the defined set
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid |-> (result_o.error_code <= ERR_RANGE))
    else $error("undefined error code");

  // unsigned 8-bit kind never passes a value above 255
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && (result_o.error_code == ERR_OK) && (kind_q == KIND_U8))
      |-> (result_o.value[32:8] == 25'd0))
    else $error("8-bit range check let a wide value through");

  // a full input register blocked by the result stage holds off new beats
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_valid && !res_ready) |-> !char_i.ready)
    else $error("input accepted while stalled");

endmodule
